[sv/abd_pkg.sv]
// ----------------------------------------------------------------------------
// abd_pkg
// shared types, constants and predictor coefficient lookup for the
// adpcm block decoder
// ----------------------------------------------------------------------------
package abd_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned FLAGS_W  = 3;
  localparam int unsigned POS_W    = 4;
  localparam int unsigned PRED_W   = 3;
  localparam int unsigned SHIFT_W  = 4;
  localparam int unsigned COEF_W   = 8;
  localparam int unsigned PROD_W   = SAMPLE_W + COEF_W;
  localparam int unsigned TAP_W    = PROD_W - 6;
  localparam int unsigned SUM_W    = TAP_W + 2;

  localparam logic [POS_W-1:0]  POS_HEADER = 4'd0;
  localparam logic [POS_W-1:0]  POS_FLAGS  = 4'd1;
  localparam logic [POS_W-1:0]  POS_LAST   = 4'd15;
  localparam logic [PRED_W-1:0] PRED_NONE  = 3'd0;
  localparam logic [3:0]        PRED_COUNT = 4'd5;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;

  typedef struct packed {
    coef_t c0;
    coef_t c1;
  } coef_pair_t;

  // predictor taps, scaled by 64
  function automatic coef_pair_t coef_lookup(input logic [PRED_W-1:0] idx);
    coef_pair_t c;
    unique case (idx)
      3'd0:    c = '{c0: 8'sd0,   c1: 8'sd0};
      3'd1:    c = '{c0: 8'sd60,  c1: 8'sd0};
      3'd2:    c = '{c0: 8'sd115, c1: -8'sd52};
      3'd3:    c = '{c0: 8'sd98,  c1: -8'sd55};
      3'd4:    c = '{c0: 8'sd122, c1: -8'sd60};
      default: c = '{c0: 8'sd0,   c1: 8'sd0};
    endcase
    return c;
  endfunction

endpackage

[sv/adpcm_block_decoder_top.sv]
// ----------------------------------------------------------------------------
// adpcm_block_decoder_top
// decodes 16-byte adpcm blocks one byte per input beat, two samples out
// per data byte
// ----------------------------------------------------------------------------
// channel  dir  tdata              tuser            tlast
// s_*      in   data_byte[7:0]     restart          -
// m_*      out  sample[15:0]       block_flags[2:0] last_of_block
//
// a data byte runs one predictor step per cycle, while the output register
// is free, through the two-tap multiply-add, low nibble then high nibble.
// header and flags bytes give no beat.
// rst clears position, header fields, flags, history and all valids.
// a stalled output holds its sample; the input register takes the next byte
// in the cycle its current byte retires.
// ----------------------------------------------------------------------------
module adpcm_block_decoder_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [abd_pkg::BYTE_W-1:0]   s_tdata,   // data_byte[7:0]
  input  logic                         s_tuser,   // restart
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [abd_pkg::SAMPLE_W-1:0] m_tdata,   // sample[15:0]
  output logic [abd_pkg::FLAGS_W-1:0]  m_tuser,   // block_flags[2:0]
  output logic                         m_tlast    // last_of_block
);
  import abd_pkg::*;

  // input register
  logic               in_valid;
  logic [BYTE_W-1:0]  in_byte;
  logic               in_restart;

  // decoder state
  logic [POS_W-1:0]   pos;
  logic [PRED_W-1:0]  pred;
  logic [SHIFT_W-1:0] shift;
  logic [FLAGS_W-1:0] flags;
  sample_t            hist1;
  sample_t            hist2;
  logic               phase;

  // output register
  logic               out_valid;
  sample_t            out_sample;
  logic [FLAGS_W-1:0] out_flags;
  logic               out_last;

  logic [POS_W-1:0]   cur_pos;
  logic               is_data;
  logic               out_free;
  logic               step;
  logic               consume;

  logic [3:0]         nib;
  sample_t            word;
  sample_t            shifted;
  coef_pair_t         coef;
  logic signed [PROD_W-1:0] prod1;
  logic signed [PROD_W-1:0] prod2;
  logic signed [TAP_W-1:0]  tap1;
  logic signed [TAP_W-1:0]  tap2;
  logic signed [SUM_W-1:0]  sum;
  sample_t            sat;

  assign cur_pos  = in_restart ? POS_HEADER : pos;
  assign is_data  = (cur_pos != POS_HEADER) && (cur_pos != POS_FLAGS);
  assign out_free = !out_valid || m_tready;
  assign step     = in_valid && is_data && out_free;
  assign consume  = in_valid && (!is_data || (step && phase));
  assign s_tready = !in_valid || consume;

  // history as seen by this step (restart only ever hits a header byte)
  assign nib     = phase ? in_byte[7:4] : in_byte[3:0];
  assign word    = sample_t'({nib, 12'h000});
  assign shifted = word >>> shift;
  assign coef    = coef_lookup(pred);
  assign prod1   = hist1 * coef.c0;
  assign prod2   = hist2 * coef.c1;
  assign tap1    = prod1[PROD_W-1:6];
  assign tap2    = prod2[PROD_W-1:6];
  assign sum     = SUM_W'(shifted) + SUM_W'(tap1) + SUM_W'(tap2);

  always_comb begin
    if (sum[SUM_W-1:SAMPLE_W-1] == '0 || sum[SUM_W-1:SAMPLE_W-1] == '1) begin
      sat = sum[SAMPLE_W-1:0];
    end else if (sum[SUM_W-1]) begin
      sat = 16'sh8000;
    end else begin
      sat = 16'sh7fff;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      in_byte    <= s_tdata;
      in_restart <= s_tuser;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos   <= POS_HEADER;
      pred  <= PRED_NONE;
      shift <= '0;
      flags <= '0;
      hist1 <= '0;
      hist2 <= '0;
      phase <= 1'b0;
    end else if (in_valid) begin
      if (cur_pos == POS_HEADER) begin
        pred  <= ({1'b0, in_byte[7:4]} < {1'b0, PRED_COUNT}) ? in_byte[6:4] : PRED_NONE;
        shift <= in_byte[3:0];
        pos   <= POS_FLAGS;
        if (in_restart) begin
          hist1 <= '0;
          hist2 <= '0;
        end
      end else if (cur_pos == POS_FLAGS) begin
        flags <= in_byte[FLAGS_W-1:0];
        pos   <= cur_pos + 4'd1;
      end else if (step) begin
        hist2 <= hist1;
        hist1 <= sat;
        phase <= !phase;
        if (phase) begin
          pos <= cur_pos + 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
    if (step) begin
      out_sample <= sat;
      out_flags  <= flags;
      out_last   <= phase && (cur_pos == POS_LAST);
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_sample;
  assign m_tuser  = out_flags;
  assign m_tlast  = out_last;

endmodule

[sim/adpcm_sample_checker.sv]
// ----------------------------------------------------------------------------
// adpcm_sample_checker
// Watches both streams of the adpcm block decoder. Each byte taken on the
// input side goes through a local copy of the decoder state; the samples
// it predicts are queued. Every output beat is compared field by field
// with the oldest queued sample.
// ----------------------------------------------------------------------------
module adpcm_sample_checker
  import abd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  input  logic                s_tready,
  input  logic [BYTE_W-1:0]   s_tdata,   // data_byte[7:0]
  input  logic                s_tuser,   // restart
  input  logic                m_tvalid,
  input  logic                m_tready,
  input  logic [SAMPLE_W-1:0] m_tdata,   // sample[15:0]
  input  logic [FLAGS_W-1:0]  m_tuser,   // block_flags[2:0]
  input  logic                m_tlast,   // last_of_block
  output int                  failures,
  output int                  waiting,
  output int                  checked
);

  typedef struct packed {
    sample_t              sample;
    logic [FLAGS_W-1:0]   flags;
    logic                 last;
  } pcm_beat_t;

  pcm_beat_t          pending_samples[$];
  logic [POS_W-1:0]   byte_pos   = '0;
  logic [PRED_W-1:0]  pred_idx   = PRED_NONE;
  logic [SHIFT_W-1:0] shift_amt  = '0;
  logic [FLAGS_W-1:0] held_flags = '0;
  sample_t            hist1      = '0;
  sample_t            hist2      = '0;
  int                 fail_cnt   = 0;
  int                 beat_cnt   = 0;

  // one predictor step: scaled nibble plus two-tap prediction, saturated
  function automatic sample_t decode_nibble(input logic [3:0] nib);
    logic signed [SAMPLE_W-1:0] word;
    int tap1;
    int tap2;
    int acc;
    case (pred_idx)
      3'd1:    begin tap1 = 60;  tap2 = 0;   end
      3'd2:    begin tap1 = 115; tap2 = -52; end
      3'd3:    begin tap1 = 98;  tap2 = -55; end
      3'd4:    begin tap1 = 122; tap2 = -60; end
      default: begin tap1 = 0;   tap2 = 0;   end
    endcase
    word = {nib, 12'h000};
    acc  = int'(word) >>> shift_amt;
    acc += (int'(hist1) * tap1) >>> 6;
    acc += (int'(hist2) * tap2) >>> 6;
    if (acc > 32767) acc = 32767;
    else if (acc < -32768) acc = -32768;
    hist2 = hist1;
    hist1 = sample_t'(acc);
    return hist1;
  endfunction

  always @(posedge clk) begin : watch
    pcm_beat_t       want;
    pcm_beat_t       lo_beat;
    pcm_beat_t       hi_beat;
    logic [POS_W-1:0] pos;
    if (rst) begin
      byte_pos   = '0;
      pred_idx   = PRED_NONE;
      shift_amt  = '0;
      held_flags = '0;
      hist1      = '0;
      hist2      = '0;
      pending_samples.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (pending_samples.size() == 0) begin
          $error("unexpected output beat: sample %0d flags %0d last %0d",
                 $signed(m_tdata), m_tuser, m_tlast);
          fail_cnt++;
        end else begin
          want = pending_samples.pop_front();
          beat_cnt++;
          if ($signed(m_tdata) !== want.sample) begin
            $error("sample: expected %0d, got %0d", want.sample, $signed(m_tdata));
            fail_cnt++;
          end
          if (m_tuser !== want.flags) begin
            $error("block_flags: expected %0d, got %0d", want.flags, m_tuser);
            fail_cnt++;
          end
          if (m_tlast !== want.last) begin
            $error("last_of_block: expected %0d, got %0d", want.last, m_tlast);
            fail_cnt++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        if (s_tuser) begin
          hist1    = '0;
          hist2    = '0;
          byte_pos = POS_HEADER;
        end
        pos      = byte_pos;
        byte_pos = byte_pos + 1'b1;
        if (pos == POS_HEADER) begin
          pred_idx  = (s_tdata[7:4] < PRED_COUNT) ? s_tdata[6:4] : PRED_NONE;
          shift_amt = s_tdata[3:0];
        end else if (pos == POS_FLAGS) begin
          held_flags = s_tdata[2:0];
        end else begin
          lo_beat.sample = decode_nibble(s_tdata[3:0]);
          lo_beat.flags  = held_flags;
          lo_beat.last   = 1'b0;
          hi_beat.sample = decode_nibble(s_tdata[7:4]);
          hi_beat.flags  = held_flags;
          hi_beat.last   = (pos == POS_LAST);
          pending_samples.push_back(lo_beat);
          pending_samples.push_back(hi_beat);
        end
      end
    end
    failures <= fail_cnt;
    waiting  <= pending_samples.size();
    checked  <= beat_cnt;
  end

endmodule

[sim/tb_adpcm_block_decoder_top.sv]
// ----------------------------------------------------------------------------
// tb_adpcm_block_decoder_top
// Feeds the adpcm block decoder with a short directed byte sequence and
// then with random blocks, truncated blocks and noise, under random stalls
// on both streams. A separate checker predicts and compares every sample.
// ----------------------------------------------------------------------------
module tb_adpcm_block_decoder_top;
  import abd_pkg::*;

  localparam int BYTE_TARGET = 1850;
  localparam int QUIET_TAIL  = 200;

  logic                clk      = 1'b0;
  logic                rst      = 1'b1;
  logic                s_tvalid = 1'b0;
  logic [BYTE_W-1:0]   s_tdata  = '0;
  logic                s_tuser  = 1'b0;
  logic                m_tready = 1'b0;
  logic                s_tready;
  logic                m_tvalid;
  logic [SAMPLE_W-1:0] m_tdata;
  logic [FLAGS_W-1:0]  m_tuser;
  logic                m_tlast;

  int failures;
  int waiting;
  int checked;
  int bytes_sent  = 0;
  int blocks_sent = 0;
  bit gaps_on     = 1'b1;
  bit quiet       = 1'b0;

  adpcm_block_decoder_top u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  adpcm_sample_checker u_checker (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .failures (failures),
    .waiting  (waiting),
    .checked  (checked)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("adpcm_block_decoder_top: mismatch");
    $finish;
  end

  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic restart);
    if (gaps_on && !quiet && $urandom_range(0, 7) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= restart;
    do @(posedge clk); while (!s_tready);
    bytes_sent++;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
  endtask

  // mostly uniform, sometimes extreme nibble pairs
  function automatic logic [BYTE_W-1:0] sample_byte();
    logic [BYTE_W-1:0] b;
    b = BYTE_W'($urandom_range(0, 255));
    if ($urandom_range(0, 7) == 0) begin
      case ($urandom_range(0, 5))
        0: b = 8'h77;
        1: b = 8'h88;
        2: b = 8'h07;
        3: b = 8'h70;
        4: b = 8'h80;
        default: b = 8'h08;
      endcase
    end
    return b;
  endfunction

  function automatic logic [BYTE_W-1:0] header_byte();
    logic [3:0] pnib;
    logic [3:0] snib;
    pnib = ($urandom_range(0, 9) < 8) ? 4'($urandom_range(0, 4))
                                      : 4'($urandom_range(5, 15));
    snib = 4'($urandom_range(0, 15));
    return {pnib, snib};
  endfunction

  // output side stalls
  initial begin
    @(negedge rst);
    forever begin
      if (gaps_on && $urandom_range(0, 9) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else if ($urandom_range(0, 19) == 0) begin
        m_tready <= 1'b1;
        repeat ($urandom_range(20, 60)) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
    end
  end

  initial begin
    bit aligned;
    bit pressed;
    bit restart;
    int kind;
    int n;
    aligned = 1'b1;
    pressed = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // stream straight from reset, no restart
    send_byte(8'h4c, 1'b0);
    send_byte(8'h07, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h7f, 1'b0);
    // predictor out of range, flag bits above bit 2
    send_byte(8'hf0, 1'b1);
    send_byte(8'hff, 1'b0);
    send_byte(8'h77, 1'b0);
    send_byte(8'h88, 1'b0);
    // saturation both ways
    send_byte(8'h40, 1'b1);
    send_byte(8'h02, 1'b0);
    repeat (3) send_byte(8'h77, 1'b0);
    repeat (2) send_byte(8'h88, 1'b0);
    // large shifts and restart mid-block
    send_byte(8'h3d, 1'b1);
    send_byte(8'h03, 1'b0);
    send_byte(8'h8f, 1'b0);
    send_byte(8'he1, 1'b0);
    send_byte(8'h2f, 1'b1);
    send_byte(8'h05, 1'b0);
    send_byte(8'h08, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h1e, 1'b1);
    send_byte(8'h04, 1'b0);
    send_byte(8'hf7, 1'b0);
    aligned = 1'b0;

    while (bytes_sent < BYTE_TARGET) begin
      if (bytes_sent >= BYTE_TARGET - QUIET_TAIL) gaps_on = 1'b0;
      if (!pressed && bytes_sent >= BYTE_TARGET / 2) begin
        drain();
        pressed = 1'b1;
      end
      quiet = ($urandom_range(0, 2) == 0);
      kind  = $urandom_range(0, 19);
      if (kind == 0) begin
        n = $urandom_range(1, 8);
        repeat (n) send_byte(BYTE_W'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
        aligned = 1'b0;
      end else if (kind == 1) begin
        send_byte(header_byte(), 1'b1);
        send_byte(BYTE_W'($urandom_range(0, 255)), 1'b0);
        n = $urandom_range(0, 10);
        repeat (n) send_byte(sample_byte(), 1'b0);
        aligned = 1'b0;
      end else begin
        restart = !aligned || ($urandom_range(0, 1) == 1);
        send_byte(header_byte(), restart);
        send_byte(BYTE_W'($urandom_range(0, 255)), 1'b0);
        repeat (14) send_byte(sample_byte(), 1'b0);
        aligned = 1'b1;
      end
      blocks_sent++;
    end

    drain();
    repeat (8) @(posedge clk);
    $display("sent %0d bytes in %0d blocks and fragments, %0d samples compared",
             bytes_sent, blocks_sent, checked);
    $display("random headers, flags and data, with mid-block restarts and stalls");
    if (failures == 0 && waiting == 0) begin
      $display("adpcm_block_decoder_top: match");
    end else begin
      $display("adpcm_block_decoder_top: mismatch");
    end
    $finish;
  end

endmodule
